/* hw/rtl/tdigest_percentile_estimator_top_defines.svh */
// Assertion macros shared by the t-digest estimator RTL.
`ifndef TDIGEST_PERCENTILE_ESTIMATOR_TOP_DEFINES_SVH
`define TDIGEST_PERCENTILE_ESTIMATOR_TOP_DEFINES_SVH

// Check a consequence in the same cycle as its antecedent.
`define TPE_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequence in the cycle after its antecedent.
`define TPE_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/tpe_pkg.sv */
// Package: constants, codes and the cluster record of the t-digest estimator.
`timescale 1ns / 1ps
package tpe_pkg;

  localparam int CLUSTER_SLOTS = 256;
  localparam int MERGED_TARGET = 64;
  localparam int TAIL_PCT      = 2;
  localparam int MERGE_RETRIES = 5;
  localparam int PCT_FULL      = 100;
  localparam int LIM_SCALE     = 4;

  localparam int SLOT_W   = $clog2(CLUSTER_SLOTS);
  localparam int CNT_W    = SLOT_W + 1;
  localparam int HALF_M   = MERGED_TARGET / 2;
  localparam int TAIL_LIM = (TAIL_PCT * MERGED_TARGET) / 100;
  localparam int FDEN     = MERGED_TARGET * MERGED_TARGET;
  localparam int KW       = $clog2(HALF_M + 1);
  localparam int TF_W     = 35;
  localparam int LIM_W    = TF_W + 2 + KW;
  localparam int ACC_W    = 32 + SLOT_W + 1;
  localparam int DIV_W    = 64;
  localparam int DCNT_W   = $clog2(DIV_W);

  localparam logic [1:0] KIND_ADD   = 2'd0;
  localparam logic [1:0] KIND_QUERY = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_EMPTY  = 2'd1;
  localparam logic [1:0] ST_BADPCT = 2'd2;

  typedef struct packed {
    logic [31:0] mean;
    logic [63:0] sum;
    logic [31:0] weight;
  } entry_t;

endpackage

/* hw/rtl/tdigest_percentile_estimator_top.sv */
// Top level: t-digest percentile estimator with sequencer, cluster memory and shared divider.
`timescale 1ns / 1ps
`include "tdigest_percentile_estimator_top_defines.svh"
// An add writes its cluster, then checks for a full table; a clear acts in the idle state.
// A query divides for the rank, scans the clusters and interpolates. A full table adds an insertion sort and up to
// six merge passes (each walks the clusters and runs the divider for every fold).
// One item at a time: busy stays high until the item is done.
// Reset: synchronous, active low; scalar digest state cleared, cluster memory not initialized.
// The receiver cannot stall: out_valid pulses for one cycle with each query result.
module tdigest_percentile_estimator_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_kind,
  input  logic [31:0] in_sample_value,
  input  logic [6:0]  in_percentile,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [31:0] out_percentile_value,
  output logic [31:0] out_sample_count
);
  import tpe_pkg::*;

  // One-hot sequencer states.
  typedef enum logic [28:0] {
    S_IDLE   = 29'd1 << 0,
    S_ADDCHK = 29'd1 << 1,
    S_MENTRY = 29'd1 << 2,
    S_SRDKEY = 29'd1 << 3,
    S_SKEY   = 29'd1 << 4,
    S_SCHK   = 29'd1 << 5,
    S_SCMP   = 29'd1 << 6,
    S_SNEXT  = 29'd1 << 7,
    S_MINIT  = 29'd1 << 8,
    S_MFIRST = 29'd1 << 9,
    S_MLIM   = 29'd1 << 10,
    S_MCHK   = 29'd1 << 11,
    S_MCMP   = 29'd1 << 12,
    S_MMEAN  = 29'd1 << 13,
    S_MEND   = 29'd1 << 14,
    S_DIV    = 29'd1 << 15,
    S_QSTART = 29'd1 << 16,
    S_QWANT  = 29'd1 << 17,
    S_QSCAN  = 29'd1 << 18,
    S_QSCMP  = 29'd1 << 19,
    S_QRDC   = 29'd1 << 20,
    S_QRDP   = 29'd1 << 21,
    S_QRDN   = 29'd1 << 22,
    S_QSEL   = 29'd1 << 23,
    S_QCALC  = 29'd1 << 24,
    S_QMUL   = 29'd1 << 25,
    S_QLDIV  = 29'd1 << 26,
    S_QLADD  = 29'd1 << 27,
    S_QCLAMP = 29'd1 << 28
  } state_t;

  // Control state (reset).
  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  used_r, used_nxt;
  logic [31:0]       total_r, total_nxt;
  logic [31:0]       min_r, min_nxt;
  logic [31:0]       max_r, max_nxt;
  logic              merged_r, merged_nxt;
  logic [2:0]        failed_r, failed_nxt;
  logic              out_valid_r, out_valid_nxt;

  // Working registers (no reset).
  state_t            div_ret_r, div_ret_nxt;
  logic              qry_r, qry_nxt;
  logic [6:0]        pct_r, pct_nxt;
  logic [CNT_W-1:0]  i_r, i_nxt;
  logic [SLOT_W-1:0] j_r, j_nxt;
  logic [SLOT_W-1:0] ci_r, ci_nxt;
  entry_t            key_r, key_nxt;
  entry_t            cur_r, cur_nxt;
  entry_t            prev_r, prev_nxt;
  entry_t            nbr_r, nbr_nxt;
  logic [TF_W-1:0]   tf_r, tf_nxt;
  logic [LIM_W-1:0]  lim_r, lim_nxt;
  logic [ACC_W-1:0]  acc_r, acc_nxt;
  logic [ACC_W-1:0]  want_r, want_nxt;
  logic [31:0]       left_r, left_nxt;
  logic [31:0]       right_r, right_nxt;
  logic [32:0]       soi_r, soi_nxt;
  logic [31:0]       sidx_r, sidx_nxt;
  logic [31:0]       v_r, v_nxt;
  logic [31:0]       mul_r, mul_nxt;
  logic [DIV_W-1:0]  div_q_r, div_q_nxt;
  logic [31:0]       div_rem_r, div_rem_nxt;
  logic [31:0]       div_d_r, div_d_nxt;
  logic [DCNT_W-1:0] div_cnt_r, div_cnt_nxt;
  logic [1:0]        out_status_r, out_status_nxt;
  logic [31:0]       out_value_r, out_value_nxt;
  logic [31:0]       out_count_r, out_count_nxt;

  // Cluster memory: one write and one registered read per cycle.
  entry_t            mem [CLUSTER_SLOTS];
  entry_t            rd_data_r;
  logic [SLOT_W-1:0] rd_addr;
  logic              wr_en;
  logic [SLOT_W-1:0] wr_addr;
  entry_t            wr_data;

  // Shared restoring divider step: one quotient bit per cycle.
  logic [32:0] div_sh, div_sub;
  logic        div_ge;
  assign div_sh  = {div_rem_r, div_q_r[DIV_W-1]};
  assign div_sub = div_sh - {1'b0, div_d_r};
  assign div_ge  = div_sh >= {1'b0, div_d_r};

  // Triangle size limit for the cluster at ci_r; the tails stay at one sample.
  logic [CNT_W-1:0] ci_e;
  logic [KW-1:0]    kk;
  logic             tail;
  logic [LIM_W-1:0] lim_prod, lim_raw, lim_calc;
  always_comb begin
    ci_e = {1'b0, ci_r};
    if (ci_e < CNT_W'(HALF_M)) begin
      kk   = KW'(ci_e + 1'b1);
      tail = ci_e < CNT_W'(TAIL_LIM);
    end else begin
      kk   = (ci_e < CNT_W'(MERGED_TARGET)) ? KW'(CNT_W'(MERGED_TARGET) - ci_e) : '0;
      tail = (ci_e + CNT_W'(TAIL_LIM)) > CNT_W'(MERGED_TARGET);
    end
    lim_prod = LIM_W'(tf_r) * LIM_W'(LIM_SCALE) * LIM_W'(kk);
    lim_raw  = lim_prod / FDEN;
    lim_calc = (tail || lim_raw == '0) ? LIM_W'(1) : lim_raw;
  end

  // Interpolation setup around the cluster the rank falls in.
  logic [31:0]      n_w;
  logic [32:0]      half_up;
  logic [ACC_W-1:0] acc_hu;
  logic             lower, is_last;
  logic [31:0]      c_v, c_left, c_right, c_sidx;
  logic [32:0]      c_soi;
  always_comb begin
    n_w     = cur_r.weight;
    half_up = ({1'b0, n_w} + 33'd1) >> 1;
    acc_hu  = acc_r + ACC_W'(half_up);
    lower   = want_r <= acc_hu;
    is_last = ({1'b0, ci_r} + 1'b1) == used_r;
    c_v     = '0;
    c_left  = '0;
    c_right = '0;
    c_sidx  = '0;
    c_soi   = '0;
    if (n_w == 32'd1 || (n_w[0] && want_r == acc_hu)) begin
      c_v = cur_r.mean;
    end else if (lower) begin
      if (ci_r == '0) begin
        if (n_w < 32'd3) begin
          c_v = min_r;
        end else begin
          c_left  = min_r;
          c_right = cur_r.mean;
          c_soi   = {1'b0, n_w} >> 1;
          c_sidx  = want_r[31:0];
        end
      end else begin
        c_soi   = ({1'b0, prev_r.weight} + {1'b0, n_w}) >> 1;
        c_left  = prev_r.mean;
        c_right = cur_r.mean;
        c_sidx  = want_r[31:0] - (acc_r[31:0] - (prev_r.weight >> 1));
      end
    end else begin
      if (is_last) begin
        if (n_w < 32'd3) begin
          c_v = max_r;
        end else begin
          c_left  = cur_r.mean;
          c_right = max_r;
          c_soi   = {1'b0, n_w} >> 1;
          c_sidx  = want_r[31:0] - (acc_r[31:0] + (n_w >> 1));
        end
      end else begin
        c_soi   = ({1'b0, nbr_r.weight} + {1'b0, n_w}) >> 1;
        c_left  = cur_r.mean;
        c_right = nbr_r.mean;
        c_sidx  = want_r[31:0] - (acc_r[31:0] + (n_w >> 1));
      end
    end
  end

  // Merge fold and scan helpers.
  logic [32:0]      prop;
  logic [63:0]      sum_new;
  logic [ACC_W-1:0] scan_next;
  logic [31:0]      v_clamp;
  assign prop      = {1'b0, cur_r.weight} + {1'b0, rd_data_r.weight};
  assign sum_new   = cur_r.sum + rd_data_r.sum;
  assign scan_next = acc_r + ACC_W'(rd_data_r.weight);
  assign v_clamp   = (v_r < min_r) ? min_r : ((v_r > max_r) ? max_r : v_r);

  // Sequencer.
  always_comb begin
    state_nxt      = state_r;
    used_nxt       = used_r;
    total_nxt      = total_r;
    min_nxt        = min_r;
    max_nxt        = max_r;
    merged_nxt     = merged_r;
    failed_nxt     = failed_r;
    out_valid_nxt  = 1'b0;
    div_ret_nxt    = div_ret_r;
    qry_nxt        = qry_r;
    pct_nxt        = pct_r;
    i_nxt          = i_r;
    j_nxt          = j_r;
    ci_nxt         = ci_r;
    key_nxt        = key_r;
    cur_nxt        = cur_r;
    prev_nxt       = prev_r;
    nbr_nxt        = nbr_r;
    tf_nxt         = tf_r;
    lim_nxt        = lim_r;
    acc_nxt        = acc_r;
    want_nxt       = want_r;
    left_nxt       = left_r;
    right_nxt      = right_r;
    soi_nxt        = soi_r;
    sidx_nxt       = sidx_r;
    v_nxt          = v_r;
    mul_nxt        = mul_r;
    div_q_nxt      = div_q_r;
    div_rem_nxt    = div_rem_r;
    div_d_nxt      = div_d_r;
    div_cnt_nxt    = div_cnt_r;
    out_status_nxt = out_status_r;
    out_value_nxt  = out_value_r;
    out_count_nxt  = out_count_r;
    rd_addr        = '0;
    wr_en          = 1'b0;
    wr_addr        = '0;
    wr_data        = cur_r;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          case (in_kind)
            KIND_ADD: begin
              // Append a one-sample cluster unless the table is full.
              if (used_r < CNT_W'(CLUSTER_SLOTS)) begin
                wr_en      = 1'b1;
                wr_addr    = used_r[SLOT_W-1:0];
                wr_data    = entry_t'{mean: in_sample_value, sum: 64'(in_sample_value),
                                      weight: 32'd1};
                if (in_sample_value > max_r) max_nxt = in_sample_value;
                if (in_sample_value < min_r) min_nxt = in_sample_value;
                used_nxt   = used_r + 1'b1;
                total_nxt  = total_r + 32'd1;
                merged_nxt = 1'b0;
              end
              state_nxt = S_ADDCHK;
            end
            KIND_QUERY: begin
              pct_nxt   = in_percentile;
              qry_nxt   = 1'b1;
              state_nxt = merged_r ? S_QSTART : S_MENTRY;
            end
            KIND_CLEAR: begin
              used_nxt   = '0;
              total_nxt  = '0;
              min_nxt    = '1;
              max_nxt    = '0;
              merged_nxt = 1'b1;
              failed_nxt = '0;
            end
            default: begin
            end
          endcase
        end
      end

      S_ADDCHK: begin
        qry_nxt   = 1'b0;
        state_nxt = (used_r >= CNT_W'(CLUSTER_SLOTS)) ? S_MENTRY : S_IDLE;
      end

      S_MENTRY: begin
        // Loop merge passes until merged or out of retries.
        if (used_r != '0 && !merged_r && failed_r <= 3'(MERGE_RETRIES)) begin
          if (failed_r == '0) begin
            i_nxt     = CNT_W'(1);
            state_nxt = S_SNEXT;
          end else begin
            state_nxt = S_MINIT;
          end
        end else begin
          state_nxt = qry_r ? S_QSTART : S_IDLE;
        end
      end

      // Insertion sort by mean, stable.
      S_SNEXT: begin
        state_nxt = (i_r < used_r) ? S_SRDKEY : S_MINIT;
      end
      S_SRDKEY: begin
        rd_addr   = i_r[SLOT_W-1:0];
        state_nxt = S_SKEY;
      end
      S_SKEY: begin
        key_nxt   = rd_data_r;
        j_nxt     = i_r[SLOT_W-1:0];
        state_nxt = S_SCHK;
      end
      S_SCHK: begin
        if (j_r == '0) begin
          wr_en     = 1'b1;
          wr_addr   = j_r;
          wr_data   = key_r;
          i_nxt     = i_r + 1'b1;
          state_nxt = S_SNEXT;
        end else begin
          rd_addr   = j_r - 1'b1;
          state_nxt = S_SCMP;
        end
      end
      S_SCMP: begin
        wr_en   = 1'b1;
        wr_addr = j_r;
        if (rd_data_r.mean > key_r.mean) begin
          wr_data   = rd_data_r;
          j_nxt     = j_r - 1'b1;
          state_nxt = S_SCHK;
        end else begin
          wr_data   = key_r;
          i_nxt     = i_r + 1'b1;
          state_nxt = S_SNEXT;
        end
      end

      // Merge pass: hold the open cluster in cur_r, write it back when it closes.
      S_MINIT: begin
        ci_nxt    = '0;
        i_nxt     = CNT_W'(1);
        tf_nxt    = TF_W'(total_r) * TF_W'({1'b0, failed_r} + 4'd1);
        rd_addr   = '0;
        state_nxt = S_MFIRST;
      end
      S_MFIRST: begin
        cur_nxt   = rd_data_r;
        state_nxt = S_MLIM;
      end
      S_MLIM: begin
        lim_nxt   = lim_calc;
        state_nxt = S_MCHK;
      end
      S_MCHK: begin
        if (i_r < used_r) begin
          rd_addr   = i_r[SLOT_W-1:0];
          state_nxt = S_MCMP;
        end else begin
          wr_en     = 1'b1;
          wr_addr   = ci_r;
          wr_data   = cur_r;
          state_nxt = S_MEND;
        end
      end
      S_MCMP: begin
        i_nxt = i_r + 1'b1;
        if (LIM_W'(prop) <= lim_r) begin
          cur_nxt.weight = prop[31:0];
          cur_nxt.sum    = sum_new;
          if (prop[31:0] == '0) begin
            cur_nxt.mean = '0;
            state_nxt    = S_MCHK;
          end else begin
            div_q_nxt   = sum_new;
            div_rem_nxt = '0;
            div_d_nxt   = prop[31:0];
            div_cnt_nxt = '0;
            div_ret_nxt = S_MMEAN;
            state_nxt   = S_DIV;
          end
        end else begin
          wr_en     = 1'b1;
          wr_addr   = ci_r;
          wr_data   = cur_r;
          ci_nxt    = ci_r + 1'b1;
          cur_nxt   = rd_data_r;
          state_nxt = S_MLIM;
        end
      end
      S_MMEAN: begin
        cur_nxt.mean = div_q_r[31:0];
        state_nxt    = S_MCHK;
      end
      S_MEND: begin
        used_nxt = {1'b0, ci_r} + 1'b1;
        if (({1'b0, ci_r} + 1'b1) > CNT_W'(MERGED_TARGET)) begin
          merged_nxt = 1'b0;
          failed_nxt = failed_r + 3'd1;
        end else begin
          merged_nxt = 1'b1;
          failed_nxt = '0;
        end
        state_nxt = S_MENTRY;
      end

      S_DIV: begin
        div_q_nxt   = {div_q_r[DIV_W-2:0], div_ge};
        div_rem_nxt = div_ge ? div_sub[31:0] : div_sh[31:0];
        div_cnt_nxt = div_cnt_r + 1'b1;
        if (div_cnt_r == DCNT_W'(DIV_W - 1)) state_nxt = div_ret_r;
      end

      // Query.
      S_QSTART: begin
        out_count_nxt = total_r;
        out_value_nxt = '0;
        if (used_r == '0) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_EMPTY;
          state_nxt      = S_IDLE;
        end else if (pct_r == '0) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_OK;
          out_value_nxt  = min_r;
          state_nxt      = S_IDLE;
        end else if (pct_r == 7'(PCT_FULL)) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_OK;
          out_value_nxt  = max_r;
          state_nxt      = S_IDLE;
        end else if (pct_r > 7'(PCT_FULL)) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_BADPCT;
          state_nxt      = S_IDLE;
        end else begin
          // Rank wanted = ceil(p * total / 100).
          div_q_nxt   = DIV_W'(39'(pct_r) * 39'(total_r));
          div_rem_nxt = '0;
          div_d_nxt   = 32'(PCT_FULL);
          div_cnt_nxt = '0;
          div_ret_nxt = S_QWANT;
          state_nxt   = S_DIV;
        end
      end
      S_QWANT: begin
        want_nxt  = div_q_r[ACC_W-1:0] + ACC_W'(div_rem_r != '0);
        acc_nxt   = '0;
        ci_nxt    = '0;
        state_nxt = S_QSCAN;
      end
      S_QSCAN: begin
        if (({1'b0, ci_r} + 1'b1) < used_r) begin
          rd_addr   = ci_r;
          state_nxt = S_QSCMP;
        end else begin
          state_nxt = S_QRDC;
        end
      end
      S_QSCMP: begin
        if (scan_next >= want_r) begin
          state_nxt = S_QRDC;
        end else begin
          acc_nxt   = scan_next;
          ci_nxt    = ci_r + 1'b1;
          state_nxt = S_QSCAN;
        end
      end
      S_QRDC: begin
        rd_addr   = ci_r;
        state_nxt = S_QRDP;
      end
      S_QRDP: begin
        cur_nxt   = rd_data_r;
        rd_addr   = ci_r - 1'b1;
        state_nxt = S_QRDN;
      end
      S_QRDN: begin
        prev_nxt  = rd_data_r;
        rd_addr   = ci_r + 1'b1;
        state_nxt = S_QSEL;
      end
      S_QSEL: begin
        nbr_nxt   = rd_data_r;
        state_nxt = S_QCALC;
      end
      S_QCALC: begin
        v_nxt     = c_v;
        left_nxt  = c_left;
        right_nxt = c_right;
        soi_nxt   = c_soi;
        sidx_nxt  = c_sidx;
        state_nxt = (c_soi != '0) ? S_QMUL : S_QCLAMP;
      end
      S_QMUL: begin
        mul_nxt = 32'((right_r - left_r) * sidx_r);
        if (right_r == left_r || soi_r[31:0] == '0) begin
          v_nxt     = left_r;
          state_nxt = S_QCLAMP;
        end else begin
          state_nxt = S_QLDIV;
        end
      end
      S_QLDIV: begin
        div_q_nxt   = DIV_W'(mul_r);
        div_rem_nxt = '0;
        div_d_nxt   = soi_r[31:0];
        div_cnt_nxt = '0;
        div_ret_nxt = S_QLADD;
        state_nxt   = S_DIV;
      end
      S_QLADD: begin
        // Round the step up, then offset from the left mean.
        v_nxt     = left_r + div_q_r[31:0] + 32'(div_rem_r != '0);
        state_nxt = S_QCLAMP;
      end
      S_QCLAMP: begin
        out_valid_nxt  = 1'b1;
        out_status_nxt = ST_OK;
        out_value_nxt  = v_clamp;
        out_count_nxt  = total_r;
        state_nxt      = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      total_r     <= '0;
      min_r       <= '1;
      max_r       <= '0;
      merged_r    <= 1'b1;
      failed_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      total_r     <= total_nxt;
      min_r       <= min_nxt;
      max_r       <= max_nxt;
      merged_r    <= merged_nxt;
      failed_r    <= failed_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    div_ret_r    <= div_ret_nxt;
    qry_r        <= qry_nxt;
    pct_r        <= pct_nxt;
    i_r          <= i_nxt;
    j_r          <= j_nxt;
    ci_r         <= ci_nxt;
    key_r        <= key_nxt;
    cur_r        <= cur_nxt;
    prev_r       <= prev_nxt;
    nbr_r        <= nbr_nxt;
    tf_r         <= tf_nxt;
    lim_r        <= lim_nxt;
    acc_r        <= acc_nxt;
    want_r       <= want_nxt;
    left_r       <= left_nxt;
    right_r      <= right_nxt;
    soi_r        <= soi_nxt;
    sidx_r       <= sidx_nxt;
    v_r          <= v_nxt;
    mul_r        <= mul_nxt;
    div_q_r      <= div_q_nxt;
    div_rem_r    <= div_rem_nxt;
    div_d_r      <= div_d_nxt;
    div_cnt_r    <= div_cnt_nxt;
    out_status_r <= out_status_nxt;
    out_value_r  <= out_value_nxt;
    out_count_r  <= out_count_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data_r <= mem[rd_addr];
  end

  assign busy                 = state_r != S_IDLE;
  assign out_valid            = out_valid_r;
  assign out_status           = out_status_r;
  assign out_percentile_value = out_value_r;
  assign out_sample_count     = out_count_r;

  `TPE_ASSERT_NOW(a_result_at_idle, out_valid_r, state_r == S_IDLE, "result strobe while busy")
  `TPE_ASSERT_NEXT(a_add_holds_busy, start && !busy && in_kind == KIND_ADD, state_r == S_ADDCHK, "add item not followed by slot check")
  `TPE_ASSERT_NOW(a_used_bound, state_r == S_IDLE, used_r <= CNT_W'(CLUSTER_SLOTS), "cluster count past table size")
  `TPE_ASSERT_NOW(a_merged_fits, merged_r && state_r == S_IDLE, used_r <= CNT_W'(MERGED_TARGET), "merged digest above target")
  `TPE_ASSERT_NOW(a_retry_bound, state_r == S_IDLE, failed_r <= 3'(MERGE_RETRIES + 1), "failed merge count past limit")

endmodule
